FILE: rtl/nswc_pkg.sv
package nswc_pkg;

    // Geometry limits
    localparam int MAX_BLOCKS           = 2048;
    localparam int WORDS_PER_SECTOR     = 128;
    localparam int MAX_SECTORS_PER_PAGE = 8;

    // Field widths
    localparam int ADDR_W        = 32;
    localparam int WORD_OFF_W    = 7;
    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int PLANE_W       = 2;
    localparam int BLK_IN_PL_W   = 11;
    localparam int PAGE_IN_BLK_W = 7;
    localparam int BUF_ADDR_W    = 10;

    // Config register widths
    localparam int SPP_W     = 2;
    localparam int PPB_W     = 3;
    localparam int BPP_W     = 4;
    localparam int PLANES_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    // Derived sizes
    localparam int BLK_W          = $clog2(MAX_BLOCKS);
    localparam int SECT_LOG2_MAX  = $clog2(MAX_SECTORS_PER_PAGE);
    localparam int OPEN_IDX_W     = BLK_W + (1 << PPB_W) - 1;
    localparam int TOTAL_W        = PLANES_W + BLK_IN_PL_W;
    localparam int MAX_BPP_LOG2   = 11;

    // Erased-block bitmap organization: rows of bits
    localparam int MAP_WORD_W = (MAX_BLOCKS >= 64) ? 32 : (MAX_BLOCKS / 2);
    localparam int MAP_ROWS   = MAX_BLOCKS / MAP_WORD_W;
    localparam int BIT_IDX_W  = $clog2(MAP_WORD_W);
    localparam int ROW_IDX_W  = $clog2(MAP_ROWS);

    localparam int SLOTS   = 4;
    localparam int SLOT_W  = $clog2(SLOTS);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 3'd0,
        CMD_FILL    = 3'd1,
        CMD_ERASE   = 3'd2,
        CMD_PROGRAM = 3'd3,
        CMD_ERROR   = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPP_LOG2    = 2'd0,
        CFG_PPB_LOG2    = 2'd1,
        CFG_BPP_LOG2    = 2'd2,
        CFG_PLANE_COUNT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [SPP_W-1:0]    spp_log2;
        logic [PPB_W-1:0]    ppb_log2;
        logic [BPP_W-1:0]    bpp_log2;
        logic [PLANES_W-1:0] plane_count;
    } cfg_t;

    typedef struct packed {
        cmd_t                     command;
        logic [PLANE_W-1:0]       plane;
        logic [BLK_IN_PL_W-1:0]   block;
        logic [PAGE_IN_BLK_W-1:0] page;
        logic [BUF_ADDR_W-1:0]    addr;
        logic [DATA_W-1:0]        data;
    } result_t;

    typedef result_t [SLOTS-1:0] result_list_t;

    // Sector-per-page log2, clamped to the page buffer size
    function automatic logic [SPP_W-1:0] eff_spp_log2(input cfg_t c);
        logic [SPP_W-1:0] l;
        l = c.spp_log2;
        if (32'(l) > SECT_LOG2_MAX)
            l = SPP_W'(SECT_LOG2_MAX);
        return l;
    endfunction

    // Blocks-per-plane log2, clamped
    function automatic logic [BPP_W-1:0] eff_bpp_log2(input cfg_t c);
        logic [BPP_W-1:0] b;
        b = c.bpp_log2;
        if (32'(b) > MAX_BPP_LOG2)
            b = BPP_W'(MAX_BPP_LOG2);
        return b;
    endfunction

endpackage

FILE: rtl/nswc_if.sv
// Input word channel
interface nswc_item_if;
    import nswc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ADDR_W-1:0]     sector_address;
    logic [WORD_OFF_W-1:0] word_offset;
    logic [DATA_W-1:0]     data_word;

    modport source (output valid, sector_address, word_offset, data_word, input ready);
    modport sink   (input valid, sector_address, word_offset, data_word, output ready);
endinterface

// Command result channel
interface nswc_result_if;
    import nswc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [PLANE_W-1:0]       plane_number;
    logic [BLK_IN_PL_W-1:0]   block_in_plane;
    logic [PAGE_IN_BLK_W-1:0] page_in_block;
    logic [BUF_ADDR_W-1:0]    buffer_word_address;
    logic [DATA_W-1:0]        write_data;
    logic                     last_command;

    modport source (output valid, command, plane_number, block_in_plane, page_in_block,
                    buffer_word_address, write_data, last_command, input ready);
    modport sink   (input valid, command, plane_number, block_in_plane, page_in_block,
                    buffer_word_address, write_data, last_command, output ready);
endinterface

FILE: rtl/nand_sector_write_combiner_unit.sv
// Page write-combining front end for a NAND device. Each request on the item
// channel is one 32-bit word of a 512-byte sector; the unit maps the sector to
// plane, block and page from the geometry registers and issues commands on the
// result channel: program the previously open page, fill the page buffer with
// 0xFF, erase a block not yet erased since reset, write the word into the page
// buffer, and program the page once its last word arrives unless the list is
// full. A word is accepted every cycle while each word yields one command and
// the result channel is ready; a word that yields more commands (at most four)
// holds the result port until its last command is taken. The word stage holds
// the word and its erased-block bitmap read (a 64 x 32 memory, one read and one
// write port, registered read, written back with forwarding); the output
// sequencer registers the command list built from them. Bitmap rows carry
// reset-cleared valid bits, so there is no clearing pass after reset. The user
// must write geometry registers only while idle; the unit does not enforce it.
module nand_sector_write_combiner_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [nswc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nswc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    nswc_item_if.sink                       item,
    nswc_result_if.source                   result
);
    import nswc_pkg::*;

    cfg_t                  cfg_reg;
    logic                  b_valid_reg;
    logic [ADDR_W-1:0]     b_sa_reg;
    logic [WORD_OFF_W-1:0] b_wo_reg;
    logic [DATA_W-1:0]     b_data_reg;
    logic                  page_open_reg;
    logic [OPEN_IDX_W-1:0] open_idx_reg;

    logic                  accept;
    logic                  b_fire;
    logic                  seq_free;
    logic [3:0]            rd_shift;
    logic [BLK_W-1:0]      rd_blk;
    logic                  erased;
    result_list_t          slots;
    logic [SLOT_W-1:0]     last_idx;
    logic                  range_err;
    logic                  erase_en;
    logic                  page_open_next;
    logic [OPEN_IDX_W-1:0] open_idx_next;

    // Handshake
    assign item.ready = !b_valid_reg || seq_free;
    assign accept     = item.valid && item.ready;
    assign b_fire     = b_valid_reg && seq_free;

    // Block number for the bitmap read
    assign rd_shift = 4'(eff_spp_log2(cfg_reg)) + 4'(cfg_reg.ppb_log2);
    assign rd_blk   = BLK_W'(item.sector_address >> rd_shift);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spp_log2    <= SPP_W'(3);
            cfg_reg.ppb_log2    <= PPB_W'(6);
            cfg_reg.bpp_log2    <= BPP_W'(10);
            cfg_reg.plane_count <= PLANES_W'(2);
        end
        else if (cfg_write_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SPP_LOG2:    cfg_reg.spp_log2    <= cfg_wdata[SPP_W-1:0];
                CFG_PPB_LOG2:    cfg_reg.ppb_log2    <= cfg_wdata[PPB_W-1:0];
                CFG_BPP_LOG2:    cfg_reg.bpp_log2    <= cfg_wdata[BPP_W-1:0];
                CFG_PLANE_COUNT: cfg_reg.plane_count <= cfg_wdata[PLANES_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Word stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_sa_reg   <= item.sector_address;
            b_wo_reg   <= item.word_offset;
            b_data_reg <= item.data_word;
        end
    end

    // Word stage control and open page state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            page_open_reg <= 1'b0;
            open_idx_reg  <= '0;
        end
        else
        begin
            if (accept)
                b_valid_reg <= 1'b1;
            else if (b_fire)
                b_valid_reg <= 1'b0;
            if (b_fire)
            begin
                page_open_reg <= page_open_next;
                open_idx_reg  <= open_idx_next;
            end
        end
    end

    nswc_bitmap u_bitmap (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .rd_blk (rd_blk),
        .wr_en  (b_fire && erase_en),
        .erased (erased)
    );

    nswc_cmd_gen u_cmd_gen (
        .cfg            (cfg_reg),
        .sector_address (b_sa_reg),
        .word_offset    (b_wo_reg),
        .data_word      (b_data_reg),
        .page_open      (page_open_reg),
        .open_idx       (open_idx_reg),
        .erased         (erased),
        .slots          (slots),
        .last_idx       (last_idx),
        .range_err      (range_err),
        .erase_en       (erase_en),
        .page_open_next (page_open_next),
        .open_idx_next  (open_idx_next)
    );

    nswc_out_seq u_out_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (b_fire),
        .slots    (slots),
        .last_idx (last_idx),
        .free     (seq_free),
        .result   (result)
    );

`ifndef NO_ASSERTIONS
    // An accepted word is in the word stage on the next cycle
    a_accept_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> b_valid_reg)
        else $error("accepted word missing from word stage");

    // A range error is always the only command of its word
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.command == CMD_ERROR) |-> result.last_command)
        else $error("range error not last command");

    // A buffer fill is always followed by at least the word write
    a_fill_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.command == CMD_FILL) |-> !result.last_command)
        else $error("fill issued as last command");

    // A rejected word leaves the open page untouched
    a_error_no_state: assert property (@(posedge clk) disable iff (!rst_n)
        (b_fire && range_err) |=> ($stable(open_idx_reg) && $stable(page_open_reg)))
        else $error("range error changed open page state");
`endif

endmodule

FILE: rtl/nswc_bitmap.sv
module nswc_bitmap (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [nswc_pkg::BLK_W-1:0] rd_blk,
    input  logic                       wr_en,
    output logic                       erased
);
    import nswc_pkg::*;

    logic [MAP_WORD_W-1:0] map_mem [MAP_ROWS];
    logic [MAP_ROWS-1:0]   row_vld_reg;
    logic [MAP_WORD_W-1:0] rd_word_reg;
    logic [MAP_WORD_W-1:0] fwd_word_reg;
    logic                  fwd_hit_reg;
    logic [ROW_IDX_W-1:0]  row_reg;
    logic [BIT_IDX_W-1:0]  bit_reg;

    logic [ROW_IDX_W-1:0]  rd_row;
    logic [BIT_IDX_W-1:0]  rd_bit;
    logic [MAP_WORD_W-1:0] cur_word;
    logic [MAP_WORD_W-1:0] new_word;

    assign rd_row = rd_blk[BLK_W-1 -: ROW_IDX_W];
    assign rd_bit = rd_blk[BIT_IDX_W-1:0];

    // Current row: forwarded write, stored row, or cleared row
    always_comb
    begin
        if (fwd_hit_reg)
            cur_word = fwd_word_reg;
        else if (row_vld_reg[row_reg])
            cur_word = rd_word_reg;
        else
            cur_word = '0;
        new_word = cur_word | (MAP_WORD_W'(1) << bit_reg);
    end

    assign erased = cur_word[bit_reg];

    // Bitmap memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            map_mem[row_reg] <= new_word;
        if (rd_en)
            rd_word_reg <= map_mem[rd_row];
    end

    // Address and forwarded row for the word in flight
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            row_reg      <= rd_row;
            bit_reg      <= rd_bit;
            fwd_word_reg <= new_word;
        end
    end

    // Row valid bits stand in for a clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                row_vld_reg[row_reg] <= 1'b1;
            if (rd_en)
                fwd_hit_reg <= wr_en && (rd_row == row_reg);
        end
    end

endmodule

FILE: rtl/nswc_cmd_gen.sv
module nswc_cmd_gen (
    input  nswc_pkg::cfg_t                       cfg,
    input  logic [nswc_pkg::ADDR_W-1:0]          sector_address,
    input  logic [nswc_pkg::WORD_OFF_W-1:0]      word_offset,
    input  logic [nswc_pkg::DATA_W-1:0]          data_word,
    input  logic                                 page_open,
    input  logic [nswc_pkg::OPEN_IDX_W-1:0]      open_idx,
    input  logic                                 erased,
    output nswc_pkg::result_list_t               slots,
    output logic [nswc_pkg::SLOT_W-1:0]          last_idx,
    output logic                                 range_err,
    output logic                                 erase_en,
    output logic                                 page_open_next,
    output logic [nswc_pkg::OPEN_IDX_W-1:0]      open_idx_next
);
    import nswc_pkg::*;

    localparam logic [WORD_OFF_W:0] WPS_EXT  = (WORD_OFF_W+1)'(WORDS_PER_SECTOR);
    localparam logic [WORD_OFF_W-1:0] LAST_WO = WORD_OFF_W'(WORDS_PER_SECTOR - 1);

    logic [SPP_W-1:0]         sl;
    logic [PPB_W-1:0]         ppb;
    logic [BPP_W-1:0]         bpp;
    logic [SECT_LOG2_MAX:0]   sl_mask;
    logic [BLK_IN_PL_W-1:0]   bpp_mask;
    logic [PAGE_IN_BLK_W-1:0] ppb_mask;
    logic [PLANES_W-1:0]      pc_eff;
    logic [TOTAL_W-1:0]       total_raw;
    logic [TOTAL_W-1:0]       total;
    logic [ADDR_W-1:0]        page_num;
    logic [ADDR_W-1:0]        blk;
    logic [ADDR_W-1:0]        old_blk;
    logic [SECT_LOG2_MAX:0]   sip;
    logic                     old_ok;
    logic                     new_page;
    logic                     need_erase;
    logic                     complete;
    logic                     closed;
    logic [SLOT_W:0]          n;
    result_t                  r;

    // Geometry decode
    always_comb
    begin
        sl       = eff_spp_log2(cfg);
        ppb      = cfg.ppb_log2;
        bpp      = eff_bpp_log2(cfg);
        sl_mask  = (SECT_LOG2_MAX+1)'(((SECT_LOG2_MAX+2)'(1) << sl) - (SECT_LOG2_MAX+2)'(1));
        bpp_mask = BLK_IN_PL_W'(((BLK_IN_PL_W+1)'(1) << bpp) - (BLK_IN_PL_W+1)'(1));
        ppb_mask = PAGE_IN_BLK_W'(((PAGE_IN_BLK_W+1)'(1) << ppb) - (PAGE_IN_BLK_W+1)'(1));
        pc_eff   = (cfg.plane_count > PLANES_W'(4)) ? PLANES_W'(4) : cfg.plane_count;
        total_raw = TOTAL_W'(pc_eff) << bpp;
        total    = (total_raw > TOTAL_W'(MAX_BLOCKS)) ? TOTAL_W'(MAX_BLOCKS) : total_raw;
        page_num = sector_address >> sl;
        blk      = page_num >> ppb;
        sip      = (SECT_LOG2_MAX+1)'(sector_address) & sl_mask;
        old_blk  = ADDR_W'(open_idx) >> ppb;
        old_ok   = old_blk < ADDR_W'(total);
        range_err = ({1'b0, word_offset} >= WPS_EXT) || (blk >= ADDR_W'(total));
        new_page = !page_open || (open_idx != page_num[OPEN_IDX_W-1:0]);
        need_erase = new_page && !erased;
        complete = (sip == sl_mask) && (word_offset == LAST_WO);
    end

    // Command list, in issue order
    always_comb
    begin
        slots  = '0;
        n      = '0;
        closed = 1'b0;
        r      = '0;
        if (range_err)
        begin
            r.command = CMD_ERROR;
            slots[0]  = r;
            n         = (SLOT_W+1)'(1);
        end
        else
        begin
            // Flush the old page
            if (new_page && page_open && old_ok)
            begin
                r         = '0;
                r.command = CMD_PROGRAM;
                r.plane   = PLANE_W'(old_blk >> bpp);
                r.block   = BLK_IN_PL_W'(old_blk) & bpp_mask;
                r.page    = PAGE_IN_BLK_W'(open_idx) & ppb_mask;
                slots[n[SLOT_W-1:0]] = r;
                n = n + 1'b1;
            end
            if (new_page)
            begin
                r         = '0;
                r.command = CMD_FILL;
                slots[n[SLOT_W-1:0]] = r;
                n = n + 1'b1;
            end
            if (need_erase)
            begin
                r         = '0;
                r.command = CMD_ERASE;
                r.plane   = PLANE_W'(blk >> bpp);
                r.block   = BLK_IN_PL_W'(blk) & bpp_mask;
                slots[n[SLOT_W-1:0]] = r;
                n = n + 1'b1;
            end
            // Buffer write
            r         = '0;
            r.command = CMD_WRITE;
            r.addr    = BUF_ADDR_W'(32'(sip) * 32'(WORDS_PER_SECTOR) + 32'(word_offset));
            r.data    = data_word;
            slots[n[SLOT_W-1:0]] = r;
            n = n + 1'b1;
            // Page complete, unless the list is already full
            if (complete && (n < (SLOT_W+1)'(SLOTS)))
            begin
                r         = '0;
                r.command = CMD_PROGRAM;
                r.plane   = PLANE_W'(blk >> bpp);
                r.block   = BLK_IN_PL_W'(blk) & bpp_mask;
                r.page    = PAGE_IN_BLK_W'(page_num) & ppb_mask;
                slots[n[SLOT_W-1:0]] = r;
                n = n + 1'b1;
                closed = 1'b1;
            end
        end
        last_idx = SLOT_W'(n - 1'b1);
    end

    // Open page update
    always_comb
    begin
        erase_en = !range_err && need_erase;
        if (range_err)
        begin
            page_open_next = page_open;
            open_idx_next  = open_idx;
        end
        else
        begin
            page_open_next = !closed;
            open_idx_next  = new_page ? page_num[OPEN_IDX_W-1:0] : open_idx;
        end
    end

endmodule

FILE: rtl/nswc_out_seq.sv
module nswc_out_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  nswc_pkg::result_list_t        slots,
    input  logic [nswc_pkg::SLOT_W-1:0]   last_idx,
    output logic                          free,
    nswc_result_if.source                 result
);
    import nswc_pkg::*;

    logic                  valid_reg;
    logic [SLOT_W-1:0]     idx_reg;
    logic [SLOT_W-1:0]     last_reg;
    result_list_t          slot_reg;
    result_t               cur;
    logic                  at_last;

    assign cur     = slot_reg[idx_reg];
    assign at_last = (idx_reg == last_reg);
    assign free    = !valid_reg || (result.ready && at_last);

    // Result port
    assign result.valid               = valid_reg;
    assign result.command             = cur.command;
    assign result.plane_number        = cur.plane;
    assign result.block_in_plane      = cur.block;
    assign result.page_in_block       = cur.page;
    assign result.buffer_word_address = cur.addr;
    assign result.write_data          = cur.data;
    assign result.last_command        = at_last;

    // Command list storage
    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= slots;
    end

    // Issue pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            last_reg  <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
            last_reg  <= last_idx;
        end
        else if (valid_reg && result.ready)
        begin
            if (at_last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule

FILE: dv/nswc_cmd_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts the command stream
// for every accepted word request and compares it with what the unit issues.
module nswc_cmd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [nswc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nswc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    nswc_item_if                            item,
    nswc_result_if                          result,
    output int unsigned                     failures,
    output int unsigned                     outstanding
);
    import nswc_pkg::*;

    typedef struct packed {
        cmd_t                     command;
        logic [PLANE_W-1:0]       plane;
        logic [BLK_IN_PL_W-1:0]   block;
        logic [PAGE_IN_BLK_W-1:0] page;
        logic [BUF_ADDR_W-1:0]    addr;
        logic [DATA_W-1:0]        data;
        logic                     last;
    } nand_cmd_t;

    // Geometry registers as the unit holds them
    logic [SPP_W-1:0]    spp_log2    = 2'd3;
    logic [PPB_W-1:0]    ppb_log2    = 3'd6;
    logic [BPP_W-1:0]    bpp_log2    = 4'd10;
    logic [PLANES_W-1:0] plane_count = 3'd2;

    // Open page tracking and erased-block bitmap
    int unsigned open_page = 0;
    bit          page_open = 1'b0;
    bit          erased_blocks [MAX_BLOCKS];

    nand_cmd_t expected_cmds [$];
    nand_cmd_t word_cmds [$];

    initial
    begin
        failures    = 0;
        outstanding = 0;
    end

    function int unsigned bpp_eff();
        return (bpp_log2 > MAX_BPP_LOG2) ? MAX_BPP_LOG2 : bpp_log2;
    endfunction

    // Planes times blocks per plane, capped at the bitmap size
    function int unsigned block_count();
        int unsigned planes;
        int unsigned blocks;
        planes = (plane_count > 4) ? 4 : plane_count;
        blocks = planes << bpp_eff();
        return (blocks > MAX_BLOCKS) ? MAX_BLOCKS : blocks;
    endfunction

    function void add_cmd(input cmd_t c, input int unsigned pl, input int unsigned blk,
                          input int unsigned pg, input int unsigned ad,
                          input logic [DATA_W-1:0] d);
        nand_cmd_t e;
        e.command = c;
        e.plane   = PLANE_W'(pl);
        e.block   = BLK_IN_PL_W'(blk);
        e.page    = PAGE_IN_BLK_W'(pg);
        e.addr    = BUF_ADDR_W'(ad);
        e.data    = d;
        e.last    = 1'b0;
        word_cmds.push_back(e);
    endfunction

    // Program an absolute page, decoded with the current geometry; dropped if
    // the page no longer lies inside the device
    function void add_program(input int unsigned page_num);
        int unsigned blk;
        int unsigned bpp;
        bpp = bpp_eff();
        blk = page_num >> ppb_log2;
        if (blk < block_count())
            add_cmd(CMD_PROGRAM, blk >> bpp, blk & ((32'd1 << bpp) - 1),
                    page_num & ((32'd1 << ppb_log2) - 1), 0, '0);
    endfunction

    // Commands caused by one word request
    function void predict_word(input logic [ADDR_W-1:0] sa, input logic [WORD_OFF_W-1:0] wo,
                               input logic [DATA_W-1:0] dw);
        int unsigned sl;
        int unsigned page_num;
        int unsigned sip;
        int unsigned blk;
        int unsigned bpp;
        // two register bits never exceed the eight-sector page buffer
        sl       = spp_log2;
        bpp      = bpp_eff();
        page_num = sa >> sl;
        sip      = sa & ((32'd1 << sl) - 1);
        blk      = page_num >> ppb_log2;
        word_cmds.delete();
        if (int'(wo) >= WORDS_PER_SECTOR || blk >= block_count())
            add_cmd(CMD_ERROR, 0, 0, 0, 0, '0);
        else
        begin
            // switching pages: flush old page, refill buffer, erase on first use
            if (!page_open || open_page != page_num)
            begin
                if (page_open)
                    add_program(open_page);
                add_cmd(CMD_FILL, 0, 0, 0, 0, '0);
                open_page = page_num;
                page_open = 1'b1;
                if (!erased_blocks[blk])
                begin
                    add_cmd(CMD_ERASE, blk >> bpp, blk & ((32'd1 << bpp) - 1), 0, 0, '0);
                    erased_blocks[blk] = 1'b1;
                end
            end
            add_cmd(CMD_WRITE, 0, 0, 0, sip * WORDS_PER_SECTOR + wo, dw);
            // last word of the page closes it, unless four commands are used up
            if (sip == (32'd1 << sl) - 1 && int'(wo) == WORDS_PER_SECTOR - 1 &&
                word_cmds.size() < SLOTS)
            begin
                add_program(page_num);
                page_open = 1'b0;
            end
        end
        word_cmds[word_cmds.size() - 1].last = 1'b1;
        foreach (word_cmds[i])
            expected_cmds.push_back(word_cmds[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        nand_cmd_t want;
        if (!rst_n)
        begin
            spp_log2    = 2'd3;
            ppb_log2    = 3'd6;
            bpp_log2    = 4'd10;
            plane_count = 3'd2;
            open_page   = 0;
            page_open   = 1'b0;
            foreach (erased_blocks[i])
                erased_blocks[i] = 1'b0;
            expected_cmds.delete();
            outstanding = 0;
        end
        else
        begin
            // register writes
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_SPP_LOG2:    spp_log2    = cfg_wdata[SPP_W-1:0];
                    CFG_PPB_LOG2:    ppb_log2    = cfg_wdata[PPB_W-1:0];
                    CFG_BPP_LOG2:    bpp_log2    = cfg_wdata[BPP_W-1:0];
                    CFG_PLANE_COUNT: plane_count = cfg_wdata[PLANES_W-1:0];
                    default: ;
                endcase
            end

            // compare an issued command with the oldest prediction
            if (result.valid && result.ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: unexpected command %0d", $realtime, result.command);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (result.command !== want.command || result.plane_number !== want.plane ||
                        result.block_in_plane !== want.block ||
                        result.page_in_block !== want.page ||
                        result.buffer_word_address !== want.addr ||
                        result.write_data !== want.data || result.last_command !== want.last)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"%0t: command mismatch\n",
                                      "  expected cmd=%0d plane=%0d blk=%0d page=%0d ",
                                      "addr=%0d data=%h last=%0d\n",
                                      "  actual   cmd=%0d plane=%0d blk=%0d page=%0d ",
                                      "addr=%0d data=%h last=%0d"},
                                     $realtime, want.command, want.plane, want.block,
                                     want.page, want.addr, want.data, want.last,
                                     result.command, result.plane_number,
                                     result.block_in_plane, result.page_in_block,
                                     result.buffer_word_address, result.write_data,
                                     result.last_command);
                    end
                end
            end

            // new word request
            if (item.valid && item.ready)
                predict_word(item.sector_address, item.word_offset, item.data_word);

            outstanding = expected_cmds.size();
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import nswc_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write_en;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int unsigned failures;
    int unsigned outstanding;

    // idle control shared by sender and receiver
    bit          gaps_on = 1'b1;
    int unsigned holdoff_requests = 0;
    int unsigned holdoff_served = 0;

    // geometry as last written, for aiming requests inside the device
    int unsigned geo_spp = 3;
    int unsigned geo_ppb = 6;
    int unsigned usable_blocks = MAX_BLOCKS;
    int unsigned words_sent = 0;

    nswc_item_if   item_ch ();
    nswc_result_if result_ch ();

    nand_sector_write_combiner_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .item         (item_ch),
        .result       (result_ch)
    );

    nswc_cmd_checker cmd_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .item         (item_ch),
        .result       (result_ch),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #1_000_000;
        $display("FAIL nand_sector_write_combiner_unit");
        $finish;
    end

    // Command receiver: random stalls, plus long hold-offs on request
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_requests != holdoff_served)
            begin
                holdoff_served++;
                result_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else
                result_ch.ready <= !(gaps_on && $urandom_range(99) < 6);
        end
    end

    // Offer one word request and wait for it to be taken
    task automatic send_word(input logic [ADDR_W-1:0] sa, input logic [WORD_OFF_W-1:0] wo,
                             input logic [DATA_W-1:0] dw);
        while (gaps_on && $urandom_range(99) < 6)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.sector_address <= sa;
        item_ch.word_offset    <= wo;
        item_ch.data_word      <= dw;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Stop offering and let every predicted command come out
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_wdata    <= CFG_DATA_W'(val);
        @(posedge clk);
    endtask

    // A few words into one page, usually ending with the page's last word
    task automatic send_page_burst();
        int unsigned page_num;
        int unsigned sect_mask;
        sect_mask = (32'd1 << geo_spp) - 1;
        page_num  = ($urandom_range(usable_blocks - 1) << geo_ppb) |
                    $urandom_range((32'd1 << geo_ppb) - 1);
        repeat ($urandom_range(4))
            send_word((page_num << geo_spp) | ($urandom & sect_mask),
                      $urandom_range(WORDS_PER_SECTOR - 1), $urandom);
        if ($urandom_range(99) < 80)
            send_word((page_num << geo_spp) | sect_mask, WORD_OFF_W'(WORDS_PER_SECTOR - 1),
                      $urandom);
    endtask

    // Stray words: anywhere, just past the device, or a lone in-range word
    task automatic send_noise();
        case ($urandom_range(2))
            0: send_word($urandom, $urandom_range(WORDS_PER_SECTOR - 1), $urandom);
            1: send_word((usable_blocks << (geo_ppb + geo_spp)) + $urandom_range(1023),
                         $urandom_range(WORDS_PER_SECTOR - 1), $urandom);
            default:
                if (usable_blocks == 0)
                    send_word($urandom, $urandom_range(WORDS_PER_SECTOR - 1), $urandom);
                else
                    send_word($urandom_range((usable_blocks << (geo_ppb + geo_spp)) - 1),
                              $urandom_range(WORDS_PER_SECTOR - 1), $urandom);
        endcase
    endtask

    initial
    begin
        int unsigned phase_geo [8][4];
        int unsigned phase_words [8];
        int unsigned first_word;
        int unsigned planes;
        int unsigned bpp;

        rst_n                  = 1'b0;
        cfg_write_en           = 1'b0;
        cfg_index              = CFG_SPP_LOG2;
        cfg_wdata              = '0;
        item_ch.valid          = 1'b0;
        item_ch.sector_address = '0;
        item_ch.word_offset    = '0;
        item_ch.data_word      = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at reset geometry: 8 sectors/page, 512 sectors/block,
        // 2048 blocks, so sectors from 2**20 on are out of range
        send_word(0, 0, 32'h0000_0000);                 // first word: fill, erase, write
        send_word(0, 127, 32'hFFFF_FFFF);               // top word offset
        send_word(7, 127, 32'hA5A5_5A5A);               // last sector, last word: program
        send_word(0, 64, 32'h0000_0001);                // reopen a programmed page
        send_word(8, 0, 32'h8000_0000);                 // next page, block already erased
        send_word(5 * 512 + 7, 127, 32'h1234_5678);     // flush+fill+erase+write, close deferred
        send_word(5 * 512 + 7, 3, 32'h5555_AAAA);       // same page stays open
        send_word(6 * 512, 1, 32'hDEAD_BEEF);           // flushes the deferred page
        send_word(32'h000F_FFFF, 127, 32'hCAFE_F00D);   // highest block and page
        send_word(32'h0010_0000, 0, 32'h0F0F_0F0F);     // first sector past the device
        send_word(32'hFFFF_FFFF, 127, 32'hFFFF_FFFF);   // all-ones address
        send_word(32'h000F_FFF8, 0, 32'h7FFF_FFFF);     // first sector of the open page
        send_word(32'h000F_FFFF, 127, 32'h0000_0000);   // now completes without deferral
        send_word(32'h000F_FFFD, 126, 32'h0000_FFFF);   // reopen top page
        send_word(32'h0000_0200, 5, 32'hFFFF_0000);     // new block while a page is open

        // Geometry per phase: sectors/page log2, pages/block log2,
        // blocks/plane log2, plane count
        phase_geo[0] = '{3, 7, 15, 7};
        phase_geo[1] = '{0, 0, 0, 1};
        phase_geo[2] = '{1, 2, 3, 0};
        phase_geo[3] = '{0, $urandom_range(2), $urandom_range(3), $urandom_range(4, 1)};
        phase_geo[4] = '{1, $urandom_range(3), $urandom_range(3), $urandom_range(4, 1)};
        phase_geo[5] = '{2, 1, $urandom_range(15, 12), $urandom_range(7, 5)};
        phase_geo[6] = '{$urandom_range(3), $urandom_range(3), $urandom_range(2),
                         $urandom_range(4, 1)};
        phase_geo[7] = '{$urandom_range(3), $urandom_range(7), $urandom_range(4),
                         $urandom_range(4, 1)};
        foreach (phase_words[p])
            phase_words[p] = (p == 2) ? 20 : 55;

        for (int p = 0; p < 8; p++)
        begin
            // registers change only with nothing in flight; an open page is kept
            drain();
            write_reg(CFG_SPP_LOG2, phase_geo[p][0]);
            write_reg(CFG_PPB_LOG2, phase_geo[p][1]);
            write_reg(CFG_BPP_LOG2, phase_geo[p][2]);
            write_reg(CFG_PLANE_COUNT, phase_geo[p][3]);
            cfg_write_en <= 1'b0;
            geo_spp       = phase_geo[p][0];
            geo_ppb       = phase_geo[p][1];
            bpp           = (phase_geo[p][2] > MAX_BPP_LOG2) ? MAX_BPP_LOG2 : phase_geo[p][2];
            planes        = (phase_geo[p][3] > 4) ? 4 : phase_geo[p][3];
            usable_blocks = ((planes << bpp) > MAX_BLOCKS) ? MAX_BLOCKS : (planes << bpp);

            gaps_on = (p != 3);
            if (p == 0 || p == 4)
                holdoff_requests++;

            first_word = words_sent;
            while (words_sent - first_word < phase_words[p])
            begin
                if (usable_blocks != 0 && $urandom_range(99) < 75)
                    send_page_burst();
                else
                    send_noise();
            end
        end

        drain();
        if (failures == 0)
            $display("PASS nand_sector_write_combiner_unit");
        else
            $display("FAIL nand_sector_write_combiner_unit");
        $finish;
    end

endmodule
